>>> hdl/dfifo_pkg.sv
// Shared types and codes for the deduplicating edge queue.
package dfifo_pkg;

    localparam int NODE_W = 10;

    typedef enum logic [1:0] {
        OP_PUSH_DIR   = 2'd0,
        OP_PUSH_UNDIR = 2'd1,
        OP_POP        = 2'd2,
        OP_POP_ALT    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_UNDIR   = 2'd0,
        KIND_TO_LOW  = 2'd1,
        KIND_TO_HIGH = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_POPPED    = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_APPLY
    } t_phase;

    typedef struct packed {
        logic [NODE_W-1:0] low;
        logic [NODE_W-1:0] high;
        t_kind             kind;
    } t_entry;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp;    // latch compare result against candidate
        logic shift;  // pop: take the neighbor's contents
        logic push;   // first free cell takes the candidate
    } t_cell_ctl;

endpackage

>>> hdl/dfifo_if.sv
// Valid/ready channels for edge requests and results.
interface dfifo_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [9:0] node_first;
    logic [9:0] node_second;

    modport source (output valid, operation, node_first, node_second, input ready);
    modport sink   (input valid, operation, node_first, node_second, output ready);
endinterface

interface dfifo_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [9:0] edge_low;
    logic [9:0] edge_high;
    logic [1:0] edge_kind;
    logic       queue_empty;

    modport source (output valid, status, edge_low, edge_high, edge_kind, queue_empty,
                    input ready);
    modport sink   (input valid, status, edge_low, edge_high, edge_kind, queue_empty,
                    output ready);
endinterface

>>> hdl/dfifo_cell.sv
// One queue slot: holds an entry, compares it with the candidate, shifts toward the head.
module dfifo_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfifo_pkg::t_cell_ctl i_ctl,
    input  dfifo_pkg::t_entry  i_cand,
    input  logic               i_prev_valid,
    input  logic               i_next_valid,
    input  dfifo_pkg::t_entry  i_next_entry,
    output logic               o_valid,
    output dfifo_pkg::t_entry  o_entry,
    output logic               o_match
);
    import dfifo_pkg::*;

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;
    logic   r_match;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_entry = i_next_entry;
        end else if (i_ctl.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_entry = i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp) begin
                r_match <= r_valid && (r_entry == i_cand);
            end
        end
    end

    // payload needs no reset; only valid entries are ever read
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

>>> hdl/dedup_edge_fifo.sv
// Top level of the deduplicating edge queue: cell row, control sequencer, result register.
//
// Usage:
//   i_in carries one request item: operation (push directed, push undirected,
//   pop), and two node indices. o_out carries exactly one result item per
//   request: status, the popped edge (zero unless popped) and queue_empty.
//   Edges are held in canonical form (low node, high node, kind); a push that
//   equals a queued edge is ignored, a push into a full queue is dropped.
// Timing:
//   A request is accepted in the idle phase, compared against every cell in
//   the next cycle (each cell latches its own match bit), and applied in the
//   apply phase once the result register is free, where the match bits are
//   OR-ed and the result register is loaded. No new request is accepted
//   until the compare-then-apply sequence over the row is done.
// Stall:
//   A new request may be accepted while the previous result waits; it is
//   compared, then held in the apply phase until the result register frees.
// Reset:
//   Synchronous active-low reset empties the queue (all cell valid bits
//   clear at once) and drops any pending result; no clearing pass is needed.
module dedup_edge_fifo #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dfifo_req_if.sink   i_in,
    dfifo_rsp_if.source o_out
);
    import dfifo_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // sequencer
    t_phase    r_phase, n_phase;
    t_op       r_op;
    t_entry    r_cand, n_cand;
    logic [CW-1:0] r_count, n_count;
    t_cell_ctl w_ctl;
    logic      w_go;

    // result register
    logic      r_out_valid, n_out_valid;
    t_status   r_status, n_status;
    t_entry    r_out_entry, n_out_entry;
    logic      r_out_empty, n_out_empty;

    // cell row
    logic   w_valid [QUEUE_DEPTH];
    t_entry w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic   w_prev_valid;
            logic   w_next_valid;
            t_entry w_next_entry;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_valid = 1'b0;
                assign w_next_entry = '0;
            end else begin : g_body
                assign w_next_valid = w_valid[g+1];
                assign w_next_entry = w_entry[g+1];
            end
            dfifo_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_cand       (r_cand),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_next_valid),
                .i_next_entry (w_next_entry),
                .o_valid      (w_valid[g]),
                .o_entry      (w_entry[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // canonical form of the incoming edge
    always_comb begin
        logic directed;
        directed = (t_op'(i_in.operation) == OP_PUSH_DIR);
        if (i_in.node_first > i_in.node_second) begin
            n_cand.low  = i_in.node_second;
            n_cand.high = i_in.node_first;
            n_cand.kind = directed ? KIND_TO_LOW : KIND_UNDIR;
        end else begin
            n_cand.low  = i_in.node_first;
            n_cand.high = i_in.node_second;
            n_cand.kind = directed ? KIND_TO_HIGH : KIND_UNDIR;
        end
    end

    assign i_in.ready = (r_phase == PH_IDLE);
    assign w_go       = !r_out_valid || o_out.ready;

    always_comb begin
        logic is_pop;
        logic full;
        is_pop      = r_op[1];     // operation 3 acts as pop
        full        = (r_count == CW'(QUEUE_DEPTH));
        n_phase     = r_phase;
        n_count     = r_count;
        w_ctl       = '0;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_out_entry = r_out_entry;
        n_out_empty = r_out_empty;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_in.valid) begin
                    n_phase = PH_CMP;
                end
            end
            PH_CMP: begin
                w_ctl.cmp = 1'b1;
                n_phase   = PH_APPLY;
            end
            PH_APPLY: begin
                if (w_go) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_out_entry = '0;
                    priority if (is_pop) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status    = ST_POPPED;
                            n_out_entry = w_entry[0];
                            w_ctl.shift = 1'b1;
                            n_count     = r_count - CW'(1);
                        end
                    end else if (|w_match) begin
                        n_status = ST_DUPLICATE;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status   = ST_PUSHED;
                        w_ctl.push = 1'b1;
                        n_count    = r_count + CW'(1);
                    end
                    n_out_empty = (n_count == '0);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= t_op'(i_in.operation);
            r_cand <= n_cand;
        end
        r_status    <= n_status;
        r_out_entry <= n_out_entry;
        r_out_empty <= n_out_empty;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.edge_low    = r_out_entry.low;
    assign o_out.edge_high   = r_out_entry.high;
    assign o_out.edge_kind   = r_out_entry.kind;
    assign o_out.queue_empty = r_out_empty;

endmodule
